/* hdl/plf_pkg.sv */
// ----------------------------------------------------------------------------
// plf_pkg
// Shared types, codes and square helpers for the playfair encryptor.
// ----------------------------------------------------------------------------
package plf_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
    localparam int NUM_LETTERS = 26;
    localparam int LW          = 5;
    localparam int PW          = $clog2(CELLS);
    localparam int RW          = $clog2(SQUARE_SIDE);

    localparam logic [LW-1:0] CODE_I = LW'(8);
    localparam logic [LW-1:0] CODE_J = LW'(9);
    localparam logic [LW-1:0] CODE_Q = LW'(16);
    localparam logic [LW-1:0] CODE_X = LW'(23);
    localparam logic [LW-1:0] LETTER_LIMIT = LW'(NUM_LETTERS);
    localparam logic [PW-1:0] CELL_LIMIT   = PW'(CELLS);

    typedef logic [LW-1:0] letter_t;
    typedef logic [PW-1:0] pos_t;
    typedef logic [RW-1:0] rc_t;

    typedef enum logic [1:0] {
        ACT_KEY    = 2'd0,
        ACT_FINISH = 2'd1,
        ACT_PLAIN  = 2'd2,
        ACT_END    = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOC_A,
        ST_LOC_B,
        ST_CALC,
        ST_RD1,
        ST_OUT1,
        ST_RD2,
        ST_OUT2
    } state_t;

    typedef struct packed {
        logic take;
        logic fill_step;
        logic loc_a;
        logic loc_b;
        logic calc;
        logic rd1;
        logic rd2;
    } plf_cmd_t;

    typedef struct packed {
        logic start_fill;
        logic pair_go;
        logic fill_done;
    } plf_status_t;

    function automatic rc_t row_of(input pos_t p);
        rc_t r;
        r = '0;
        for (int i = 1; i < SQUARE_SIDE; i++) begin
            if (p >= PW'(i * SQUARE_SIDE)) begin
                r = RW'(i);
            end
        end
        return r;
    endfunction

    function automatic rc_t col_of(input pos_t p);
        pos_t base;
        base = PW'(row_of(p)) * PW'(SQUARE_SIDE);
        return RW'(p - base);
    endfunction

    function automatic rc_t wrap_inc(input rc_t v);
        rc_t r;
        if (v == RW'(SQUARE_SIDE - 1)) begin
            r = '0;
        end else begin
            r = v + RW'(1);
        end
        return r;
    endfunction

    function automatic pos_t cell_index(input rc_t row, input rc_t col);
        return PW'(PW'(row) * PW'(SQUARE_SIDE) + PW'(col));
    endfunction

endpackage

/* hdl/plf_in_if.sv */
// ----------------------------------------------------------------------------
// plf_in_if
// Input channel: action and letter with valid/ready.
// ----------------------------------------------------------------------------
interface plf_in_if;
    import plf_pkg::*;

    logic          valid;
    logic          ready;
    logic [1:0]    action;
    logic [LW-1:0] letter;

    modport source (output valid, output action, output letter, input ready);
    modport sink   (input valid, input action, input letter, output ready);
endinterface

/* hdl/plf_out_if.sv */
// ----------------------------------------------------------------------------
// plf_out_if
// Output channel: cipher letter and pair marker with valid/ready.
// ----------------------------------------------------------------------------
interface plf_out_if;
    import plf_pkg::*;

    logic          valid;
    logic          ready;
    logic [LW-1:0] cipher_letter;
    logic          pair_last;

    modport source (output valid, output cipher_letter, output pair_last, input ready);
    modport sink   (input valid, input cipher_letter, input pair_last, output ready);
endinterface

/* hdl/plf_ctrl.sv */
// ----------------------------------------------------------------------------
// plf_ctrl
// Sequencer: handshakes, key fill sweep and pair encryption steps.
// ----------------------------------------------------------------------------
module plf_ctrl
    import plf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  plf_status_t status,
    output plf_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.take = 1'b1;
                    if (status.start_fill) begin
                        state_next = ST_FILL;
                    end else if (status.pair_go) begin
                        state_next = ST_LOC_A;
                    end
                end
            end
            ST_FILL:
            begin
                if (status.fill_done) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.fill_step = 1'b1;
                end
            end
            ST_LOC_A:
            begin
                cmd.loc_a  = 1'b1;
                state_next = ST_LOC_B;
            end
            ST_LOC_B:
            begin
                cmd.loc_b  = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.rd1    = 1'b1;
                state_next = ST_OUT1;
            end
            ST_OUT1:
            begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = ST_RD2;
                end
            end
            ST_RD2:
            begin
                cmd.rd2    = 1'b1;
                state_next = ST_OUT2;
            end
            ST_OUT2:
            begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/plf_dp.sv */
// ----------------------------------------------------------------------------
// plf_dp
// Datapath: key square, letter positions, pairing and cipher lookup.
// ----------------------------------------------------------------------------
module plf_dp
    import plf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  plf_cmd_t      cmd,
    output plf_status_t   status,
    input  logic [1:0]    action,
    input  logic [LW-1:0] letter,
    output logic [LW-1:0] cipher_letter,
    output logic          pair_last
);

    letter_t key_mem [CELLS];
    pos_t    pos_mem [NUM_LETTERS];

    logic [NUM_LETTERS-1:0] used_reg, used_next;
    pos_t    filled_reg, filled_next;
    letter_t pend_reg, pend_next;
    logic    pv_reg, pv_next;
    letter_t k_reg, k_next;

    letter_t a_reg, b_reg;
    pos_t    pa_reg, pb_reg;
    logic    fa_reg, fb_reg;
    pos_t    idx1_reg, idx2_reg;
    letter_t q_reg;
    logic    q_ok_reg;
    logic    pair_last_reg;

    letter_t code;
    logic    code_ok, space_ok, plain_ok, end_go;
    logic    wr_en;
    letter_t wr_letter;
    letter_t b_sel;

    pos_t pa, pb;
    rc_t  ra, ca, rb, cb;
    pos_t idx1, idx2;

    always_comb
    begin
        code     = (letter == CODE_J) ? CODE_I : letter;
        code_ok  = code < LETTER_LIMIT;
        space_ok = filled_reg < CELL_LIMIT;
        plain_ok = cmd.take && (action == ACT_PLAIN) && code_ok;
        end_go   = cmd.take && (action == ACT_END) && pv_reg;

        status.start_fill = action == ACT_FINISH;
        status.pair_go    = ((action == ACT_PLAIN) && code_ok && pv_reg)
                          || ((action == ACT_END) && pv_reg);
        status.fill_done  = (k_reg >= LETTER_LIMIT) || !space_ok;

        wr_en     = 1'b0;
        wr_letter = code;
        if (cmd.take && (action == ACT_KEY) && code_ok && space_ok && !used_reg[code]) begin
            wr_en = 1'b1;
        end else if (cmd.fill_step && (k_reg < LETTER_LIMIT) && space_ok
                     && (k_reg != CODE_J) && !used_reg[k_reg]) begin
            wr_en     = 1'b1;
            wr_letter = k_reg;
        end

        used_next   = used_reg;
        filled_next = filled_reg;
        if (wr_en) begin
            used_next[wr_letter] = 1'b1;
            filled_next          = filled_reg + PW'(1);
        end

        k_next = k_reg;
        if (cmd.take) begin
            k_next = '0;
        end else if (cmd.fill_step) begin
            k_next = k_reg + LW'(1);
        end

        if (pend_reg == code) begin
            b_sel = (pend_reg == CODE_X) ? CODE_Q : CODE_X;
        end else begin
            b_sel = code;
        end

        pend_next = pend_reg;
        pv_next   = pv_reg;
        if (plain_ok) begin
            if (!pv_reg) begin
                pend_next = code;
                pv_next   = 1'b1;
            end else if (pend_reg != code) begin
                pv_next = 1'b0;
            end
        end else if (end_go) begin
            pv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            used_reg   <= '0;
            filled_reg <= '0;
            pend_reg   <= '0;
            pv_reg     <= 1'b0;
            k_reg      <= '0;
        end else begin
            used_reg   <= used_next;
            filled_reg <= filled_next;
            pend_reg   <= pend_next;
            pv_reg     <= pv_next;
            k_reg      <= k_next;
        end
    end

    // square and position stores
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            key_mem[filled_reg] <= wr_letter;
            pos_mem[wr_letter]  <= filled_reg;
        end
        if (cmd.loc_a) begin
            pa_reg <= pos_mem[a_reg];
        end
        if (cmd.loc_b) begin
            pb_reg <= pos_mem[b_reg];
        end
        if (cmd.rd1) begin
            q_reg <= key_mem[idx1_reg];
        end else if (cmd.rd2) begin
            q_reg <= key_mem[idx2_reg];
        end
    end

    always_comb
    begin
        pa = fa_reg ? pa_reg : '0;
        pb = fb_reg ? pb_reg : '0;
        ra = row_of(pa);
        ca = col_of(pa);
        rb = row_of(pb);
        cb = col_of(pb);
        if (ra == rb) begin
            idx1 = cell_index(ra, wrap_inc(ca));
            idx2 = cell_index(rb, wrap_inc(cb));
        end else if (ca == cb) begin
            idx1 = cell_index(wrap_inc(ra), ca);
            idx2 = cell_index(wrap_inc(rb), cb);
        end else begin
            idx1 = cell_index(ra, cb);
            idx2 = cell_index(rb, ca);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take) begin
            a_reg <= pend_reg;
            b_reg <= (action == ACT_END) ? CODE_X : b_sel;
        end
        if (cmd.loc_a) begin
            fa_reg <= used_reg[a_reg];
        end
        if (cmd.loc_b) begin
            fb_reg <= used_reg[b_reg];
        end
        if (cmd.calc) begin
            idx1_reg <= idx1;
            idx2_reg <= idx2;
        end
        if (cmd.rd1) begin
            q_ok_reg      <= idx1_reg < filled_reg;
            pair_last_reg <= 1'b0;
        end else if (cmd.rd2) begin
            q_ok_reg      <= idx2_reg < filled_reg;
            pair_last_reg <= 1'b1;
        end
    end

    assign cipher_letter = q_ok_reg ? q_reg : '0;
    assign pair_last     = pair_last_reg;

endmodule

/* hdl/playfair_digraph_encryptor_unit.sv */
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor_unit
// Playfair encryptor over a 5x5 key square built from key letters.
//
//   channel     dir   payload
//   plain_ch    in    action[1:0], letter[4:0]
//   cipher_ch   out   cipher_letter[4:0], pair_last
//
// key letter and lone plaintext letter items are taken without leaving idle.
// key finish sweeps the alphabet, one letter a cycle, until the square is full.
// a pair runs two position reads and one index step, then one square read
// and one output beat per cipher letter; each beat holds while output stalls.
// reset clears the square fill, the used-letter map and the pending letter.
// ----------------------------------------------------------------------------
module playfair_digraph_encryptor_unit
    import plf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    plf_in_if.sink     plain_ch,
    plf_out_if.source  cipher_ch
);

    plf_cmd_t    cmd;
    plf_status_t status;

    plf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (plain_ch.valid),
        .in_ready  (plain_ch.ready),
        .out_valid (cipher_ch.valid),
        .out_ready (cipher_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    plf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .action        (plain_ch.action),
        .letter        (plain_ch.letter),
        .cipher_letter (cipher_ch.cipher_letter),
        .pair_last     (cipher_ch.pair_last)
    );

endmodule
